>>> design/dram_request_splitter_tracker_defines.svh
// Assertion macros shared by the request splitter / tracker modules.
`ifndef DRAM_REQUEST_SPLITTER_TRACKER_DEFINES_SVH
`define DRAM_REQUEST_SPLITTER_TRACKER_DEFINES_SVH

// Same-cycle check, disabled while reset is asserted.
`define DRST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DRST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/drst_pkg.sv
// Package: beat types, control structs and constants of the request splitter / tracker.
`timescale 1ns / 1ps
package drst_pkg;

	// operation of an incoming beat
	localparam logic OP_NEW  = 1'b0;
	localparam logic OP_CMPL = 1'b1;

	// result kinds
	localparam logic OUT_SUB = 1'b0;
	localparam logic OUT_ACK = 1'b1;

	// memory operation kinds
	localparam logic [1:0] KIND_READ = 2'd0;
	localparam logic [1:0] KIND_INST = 2'd2;

	// configuration register indexes and widths
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_LOG2 = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_LOG2  = 1'b1;

	// register reset values and legal ranges
	localparam logic [3:0] LINE_LOG2_RST = 4'd6;
	localparam logic [4:0] ROW_LOG2_RST  = 5'd11;
	localparam logic [3:0] LINE_LOG2_MIN = 4'd6;
	localparam logic [3:0] LINE_LOG2_MAX = 4'd12;
	localparam logic [4:0] ROW_LOG2_MIN  = 5'd6;
	localparam logic [4:0] ROW_LOG2_MAX  = 5'd16;

	// outstanding counter saturation value
	localparam logic [6:0] CNT_MAX = 7'd127;

	typedef struct packed {
		logic        op;
		logic [63:0] address;
		logic [11:0] size_bytes;
		logic [1:0]  op_kind;
		logic        load_from_write;
		logic [3:0]  parent_tag;
		logic [31:0] latency;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [63:0] sub_address;
		logic [12:0] sub_size;
		logic [1:0]  sub_op_kind;
		logic [3:0]  tag_out;
		logic        last;
		logic        parent_done;
		logic        error;
		logic [47:0] kind_op_count;
		logic [63:0] kind_latency_sum;
		logic [31:0] kind_latency_min;
		logic [31:0] kind_latency_max;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch the accepted request beat
		logic prep;      // compute split, load address/count, bump outstanding
		logic issue;     // load one sub-request into the output register
		logic complete;  // update tracking/stats, load the acknowledgement
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic req_op;    // op of the beat on the request port
		logic n_zero;    // latched request produces no sub-request
		logic last_sub;  // one sub-request left
		logic out_free;  // output register can take a beat this cycle
	} sts_t;

endpackage

>>> design/dram_request_splitter_tracker.sv
// Top level of the memory request splitter with per-parent completion tracking.
`timescale 1ns / 1ps
// A request beat (op = 0) is cut into sub-requests aligned to a unit of
// 2^min(line_bytes_log2, row_buffer_bytes_log2) bytes, each register first
// saturated into its legal range (line 6..12, row buffer 6..16). Sub-requests
// cover the aligned base through address + size_bytes, go out in ascending
// order, and the final one carries last; instruction fetches and
// load_from_write requests go out as reads. At most MAX_SUBS sub-requests are
// issued per request, and each raises the outstanding count of parent_tag
// (saturating at 127; tags at or above TAG_SLOTS are not counted). A
// completion beat (op = 1) lowers that count and returns one acknowledgement
// with parent_done and the running count, wrapping latency sum, minimum and
// maximum of its kind. A completion for a tag with nothing outstanding is
// flagged with error and changes nothing. Timing: the block handles one
// request at a time through a four-state sequencer and a single output
// register. A request passes through accept, a prepare step for the split
// arithmetic and outstanding update, then one issue step per sub-request
// while the output register is free; a completion passes through accept,
// then one update-and-report step. A request whose size is zero at an
// aligned address yields no beat and returns to idle after the prepare step.
// The next request is accepted while the last result beat still waits in the
// output register. Configuration writes take effect at once and must only be
// issued while the block is idle.
module dram_request_splitter_tracker
	import drst_pkg::*;
#(
	parameter int TAG_SLOTS = 16,  // outstanding-table slots, 2..256
	parameter int OP_KINDS  = 4,   // kinds with statistics, 3..16
	parameter int MAX_SUBS  = 64   // cap on sub-requests per request, 2..64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request / completion beats
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req_data,
	// sub-request / acknowledgement beats
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp_data,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: owns the request handshake, steps the datapath
	drst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: split math, outstanding table, statistics, output register
	drst_dp #(
		.TAG_SLOTS (TAG_SLOTS),
		.OP_KINDS  (OP_KINDS),
		.MAX_SUBS  (MAX_SUBS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

>>> design/drst_ctrl.sv
// Sequencer for the request splitter / tracker: accept, prepare, issue, complete.
`timescale 1ns / 1ps
`include "dram_request_splitter_tracker_defines.svh"
module drst_ctrl
	import drst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_PREP  = 4'b0010,
		ST_ISSUE = 4'b0100,
		ST_CMPL  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = (sts.req_op == OP_CMPL) ? ST_CMPL : ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = sts.n_zero ? ST_IDLE : ST_ISSUE;
			end
			ST_ISSUE: begin
				if (sts.out_free) begin
					cmd.issue = 1'b1;
					if (sts.last_sub) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CMPL: begin
				if (sts.out_free) begin
					cmd.complete = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`DRST_ASSERT_NEXT(a_last_sub_ends, clk, arst_n,
		state_q == ST_ISSUE && sts.out_free && sts.last_sub, state_q == ST_IDLE,
		"final sub-request did not return the sequencer to idle")
	`DRST_ASSERT_NEXT(a_new_req_preps, clk, arst_n,
		cmd.capture && sts.req_op == OP_NEW, state_q == ST_PREP,
		"new request beat not followed by the prepare step")
	`DRST_ASSERT(a_one_cmd, clk, arst_n,
		$onehot0({cmd.capture, cmd.prep, cmd.issue, cmd.complete}),
		"more than one datapath command in a cycle")

endmodule

>>> design/drst_dp.sv
// Datapath: request latch, split arithmetic, outstanding table, per-kind stats, output register.
`timescale 1ns / 1ps
`include "dram_request_splitter_tracker_defines.svh"
module drst_dp
	import drst_pkg::*;
#(
	parameter int TAG_SLOTS = 16,
	parameter int OP_KINDS  = 4,
	parameter int MAX_SUBS  = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  req_t                  req_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp_data,
	input  cmd_t                  cmd,
	output sts_t                  sts
);

	localparam int TAG_IW  = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
	localparam int KIND_IW = (OP_KINDS > 1) ? $clog2(OP_KINDS) : 1;
	localparam int SUB_W   = $clog2(MAX_SUBS + 1);

	// configuration
	logic [3:0] line_log2_q;
	logic [4:0] row_log2_q;

	// latched request beat
	req_t cap_q;

	// split state
	logic [63:0]      next_addr_q;
	logic [SUB_W-1:0] subs_left_q;

	// tracking and statistics
	logic [6:0]  outst_q [TAG_SLOTS];
	logic [47:0] kcnt_q  [OP_KINDS];
	logic [63:0] ksum_q  [OP_KINDS];
	logic [31:0] kmin_q  [OP_KINDS];
	logic [31:0] kmax_q  [OP_KINDS];

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	// ---- split arithmetic ----
	logic [3:0]  ls, sh;
	logic [4:0]  rs;
	logic [12:0] unit;
	logic [11:0] off_mask, offset;
	logic [12:0] total;
	logic [13:0] round_up;
	logic [7:0]  n_raw, n_clamp;
	logic [63:0] base;
	logic [1:0]  sub_kind;

	always_comb begin
		if (line_log2_q < LINE_LOG2_MIN) begin
			ls = LINE_LOG2_MIN;
		end else if (line_log2_q > LINE_LOG2_MAX) begin
			ls = LINE_LOG2_MAX;
		end else begin
			ls = line_log2_q;
		end
		if (row_log2_q < ROW_LOG2_MIN) begin
			rs = ROW_LOG2_MIN;
		end else if (row_log2_q > ROW_LOG2_MAX) begin
			rs = ROW_LOG2_MAX;
		end else begin
			rs = row_log2_q;
		end
		sh       = ({1'b0, ls} < rs) ? ls : rs[3:0];
		unit     = 13'd1 << sh;
		off_mask = 12'(unit - 13'd1);
		offset   = cap_q.address[11:0] & off_mask;
		total    = {1'b0, cap_q.size_bytes} + {1'b0, offset};
		round_up = {1'b0, total} + {1'b0, unit} - 14'd1;
		n_raw    = 8'(round_up >> sh);
		n_clamp  = (n_raw > 8'(MAX_SUBS)) ? 8'(MAX_SUBS) : n_raw;
		base     = cap_q.address & ~{52'd0, off_mask};
		sub_kind = (cap_q.load_from_write || cap_q.op_kind == KIND_INST) ?
			KIND_READ : cap_q.op_kind;
	end

	// ---- completion arithmetic ----
	logic              tag_ok, kind_ok, err, done, upd;
	logic [TAG_IW-1:0] tidx;
	logic [KIND_IW-1:0] kidx;
	logic [6:0]        cur_cnt, dec_cnt;
	logic [8:0]        add_cnt;
	logic [47:0]       k_cnt, n_cnt;
	logic [63:0]       k_sum, n_sum;
	logic [31:0]       k_min, n_min, k_max, n_max;

	always_comb begin
		tag_ok  = 32'(cap_q.parent_tag) < TAG_SLOTS;
		kind_ok = 32'(cap_q.op_kind) < OP_KINDS;
		tidx    = TAG_IW'(cap_q.parent_tag);
		kidx    = KIND_IW'(cap_q.op_kind);
		cur_cnt = tag_ok ? outst_q[tidx] : 7'd0;
		add_cnt = 9'(cur_cnt) + 9'(n_clamp);
		err     = (cur_cnt == 7'd0);
		dec_cnt = cur_cnt - 7'd1;
		done    = !err && (dec_cnt == 7'd0);
		upd     = !err && kind_ok;
		k_cnt   = kind_ok ? kcnt_q[kidx] : 48'd0;
		k_sum   = kind_ok ? ksum_q[kidx] : 64'd0;
		k_min   = kind_ok ? kmin_q[kidx] : 32'd0;
		k_max   = kind_ok ? kmax_q[kidx] : 32'd0;
		n_cnt   = k_cnt + 48'd1;
		n_sum   = k_sum + 64'(cap_q.latency);
		n_min   = (cap_q.latency < k_min) ? cap_q.latency : k_min;
		n_max   = (cap_q.latency > k_max) ? cap_q.latency : k_max;
	end

	// ---- result beats ----
	rsp_t sub_beat, ack_beat;

	always_comb begin
		sub_beat             = '0;
		sub_beat.kind        = OUT_SUB;
		sub_beat.sub_address = next_addr_q;
		sub_beat.sub_size    = unit;
		sub_beat.sub_op_kind = sub_kind;
		sub_beat.tag_out     = cap_q.parent_tag;
		sub_beat.last        = (subs_left_q == SUB_W'(1));

		ack_beat                  = '0;
		ack_beat.kind             = OUT_ACK;
		ack_beat.sub_op_kind      = cap_q.op_kind;
		ack_beat.tag_out          = cap_q.parent_tag;
		ack_beat.last             = 1'b1;
		ack_beat.parent_done      = done;
		ack_beat.error            = err;
		ack_beat.kind_op_count    = upd ? n_cnt : k_cnt;
		ack_beat.kind_latency_sum = upd ? n_sum : k_sum;
		ack_beat.kind_latency_min = upd ? n_min : k_min;
		ack_beat.kind_latency_max = upd ? n_max : k_max;
	end

	// ---- status ----
	assign sts.req_op   = req_data.op;
	assign sts.n_zero   = (n_raw == 8'd0);
	assign sts.last_sub = (subs_left_q == SUB_W'(1));
	assign sts.out_free = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// configuration and request latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_log2_q <= LINE_LOG2_RST;
			row_log2_q  <= ROW_LOG2_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_LOG2: line_log2_q <= cfg_data[3:0];
				REG_ROW_LOG2:  row_log2_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cap_q <= req_data;
		end
	end

	// split sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_addr_q <= '0;
			subs_left_q <= '0;
		end else if (cmd.prep) begin
			next_addr_q <= base;
			subs_left_q <= SUB_W'(n_clamp);
		end else if (cmd.issue) begin
			next_addr_q <= next_addr_q + 64'(unit);
			subs_left_q <= subs_left_q - SUB_W'(1);
		end
	end

	// outstanding table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAG_SLOTS; i++) begin
				outst_q[i] <= '0;
			end
		end else if (cmd.prep && tag_ok) begin
			outst_q[tidx] <= (add_cnt > 9'(CNT_MAX)) ? CNT_MAX : add_cnt[6:0];
		end else if (cmd.complete && tag_ok && !err) begin
			outst_q[tidx] <= dec_cnt;
		end
	end

	// per-kind statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < OP_KINDS; i++) begin
				kcnt_q[i] <= '0;
				ksum_q[i] <= '0;
				kmin_q[i] <= '1;
				kmax_q[i] <= '0;
			end
		end else if (cmd.complete && upd) begin
			kcnt_q[kidx] <= n_cnt;
			ksum_q[kidx] <= n_sum;
			kmin_q[kidx] <= n_min;
			kmax_q[kidx] <= n_max;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.issue || cmd.complete) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rsp_q <= sub_beat;
		end else if (cmd.complete) begin
			rsp_q <= ack_beat;
		end
	end

	`DRST_ASSERT_NEXT(a_issue_advances, clk, arst_n,
		cmd.issue && subs_left_q > SUB_W'(1),
		subs_left_q == $past(subs_left_q) - SUB_W'(1) &&
		next_addr_q == $past(next_addr_q) + 64'($past(unit)),
		"sub-request issue did not advance address and count")
	`DRST_ASSERT(a_err_not_done, clk, arst_n,
		!(rsp_valid_q && rsp_q.error && rsp_q.parent_done),
		"completion flagged both error and parent done")

endmodule
